// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the sample table walker checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define MSTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mstw check failed");
// Condition that must never be seen outside reset.
`define MSTW_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mstw forbidden condition");
`endif

// ----- rtl/core/mstw_pkg.sv -----
// Shared types, codes and sizes of the sample table walker.
// No dependencies.
`timescale 1ns / 1ps
package mstw_pkg;

  localparam int RUN_DEPTH   = 64;
  localparam int CHUNK_DEPTH = 1024;
  localparam int SIZE_DEPTH  = 4096;
  localparam int TIME_DEPTH  = 64;

  localparam int RUN_AW   = $clog2(RUN_DEPTH);
  localparam int CHUNK_AW = $clog2(CHUNK_DEPTH);
  localparam int SIZE_AW  = $clog2(SIZE_DEPTH);
  localparam int TIME_AW  = $clog2(TIME_DEPTH);
  localparam int RUN_CW   = $clog2(RUN_DEPTH + 1);
  localparam int CHUNK_CW = $clog2(CHUNK_DEPTH + 1);
  localparam int SIZE_CW  = $clog2(SIZE_DEPTH + 1);
  localparam int TIME_CW  = $clog2(TIME_DEPTH + 1);

  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_RUN    = 3'd1;
  localparam logic [2:0] FUNC_CHUNK  = 3'd2;
  localparam logic [2:0] FUNC_SIZE   = 3'd3;
  localparam logic [2:0] FUNC_TIME   = 3'd4;
  localparam logic [2:0] FUNC_NEXT   = 3'd5;

  localparam logic [2:0] ST_LOADED     = 3'd0;
  localparam logic [2:0] ST_GIVEN      = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NOMORE     = 3'd3;
  localparam logic [2:0] ST_CHUNKS_OUT = 3'd4;
  localparam logic [2:0] ST_MISSING    = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] value_a;
    logic [31:0] value_b;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] sample_offset;
    logic [31:0] sample_length;
    logic [63:0] sample_time;
    logic [31:0] sample_duration;
    logic [11:0] sample_index;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHUNK, S_RUN_RD, S_RUN_CMP, S_CHUNK_LOAD,
    S_SIZE, S_TIME, S_TIME_LOAD, S_GIVE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] emit_code;
    logic       chunk_start;
    logic       run_rd;
    logic       run_cmp;
    logic       chunk_load;
    logic       size_rd;
    logic       size_use;
    logic       time_rd;
    logic       time_load;
    logic       give;
  } cmd_t;

  typedef struct packed {
    logic missing;
    logic nomore;
    logic left_zero;
    logic chunks_out;
    logic run_stop;
    logic run_last;
    logic time_need;
  } stat_t;

endpackage

// ----- rtl/core/mstw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mstw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/mstw_ctrl.sv -----
// Sequencer of the sample table walker: walks chunks, runs, sizes and time runs.
// Depends on mstw_pkg.
`timescale 1ns / 1ps
module mstw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2:0]     func_i,
  input  mstw_pkg::stat_t stat_i,
  output mstw_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import mstw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && func_i == FUNC_NEXT && !stat_i.missing && !stat_i.nomore) begin
          state_d = S_CHUNK;
        end
      end
      S_CHUNK: begin
        if (stat_i.left_zero) begin
          state_d = stat_i.chunks_out ? S_IDLE : S_RUN_RD;
        end else begin
          state_d = S_SIZE;
        end
      end
      S_RUN_RD:     state_d = S_RUN_CMP;
      S_RUN_CMP: begin
        if (stat_i.run_stop || stat_i.run_last) begin
          state_d = S_CHUNK_LOAD;
        end else begin
          state_d = S_RUN_RD;
        end
      end
      S_CHUNK_LOAD: state_d = S_CHUNK;
      S_SIZE:       state_d = S_TIME;
      S_TIME:       state_d = stat_i.time_need ? S_TIME_LOAD : S_GIVE;
      S_TIME_LOAD:  state_d = S_TIME;
      S_GIVE:       state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i < FUNC_NEXT) begin
            cmd_o.load = 1'b1;
          end else if (func_i == FUNC_NEXT) begin
            if (stat_i.missing) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = ST_MISSING;
            end else if (stat_i.nomore) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = ST_NOMORE;
            end
          end
        end
      end
      S_CHUNK: begin
        if (stat_i.left_zero) begin
          if (stat_i.chunks_out) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_code = ST_CHUNKS_OUT;
          end else begin
            cmd_o.chunk_start = 1'b1;
          end
        end else begin
          cmd_o.size_rd = 1'b1;
        end
      end
      S_RUN_RD:     cmd_o.run_rd = 1'b1;
      S_RUN_CMP:    cmd_o.run_cmp = 1'b1;
      S_CHUNK_LOAD: cmd_o.chunk_load = 1'b1;
      S_SIZE:       cmd_o.size_use = 1'b1;
      S_TIME:       cmd_o.time_rd = stat_i.time_need;
      S_TIME_LOAD:  cmd_o.time_load = 1'b1;
      S_GIVE:       cmd_o.give = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

// ----- rtl/core/mstw_dpath.sv -----
// Datapath of the sample table walker: table RAMs, fill counts, walk state, result.
// Depends on mstw_pkg and mstw_ram.
`timescale 1ns / 1ps
module mstw_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mstw_pkg::in_t   in_i,
  input  logic [31:0]     constant_size_i,
  input  logic [12:0]     sample_total_i,
  input  mstw_pkg::cmd_t  cmd_i,
  output mstw_pkg::stat_t stat_o,
  output logic            res_valid_o,
  output mstw_pkg::res_t  res_o
);
  import mstw_pkg::*;

  logic [RUN_CW-1:0]   run_entries_q, run_entries_d;
  logic [CHUNK_CW-1:0] chunk_entries_q, chunk_entries_d;
  logic [SIZE_CW-1:0]  size_entries_q, size_entries_d;
  logic [TIME_CW-1:0]  time_entries_q, time_entries_d;
  logic [CHUNK_CW-1:0] chunk_pos_q, chunk_pos_d;
  logic [31:0]         left_chunk_q, left_chunk_d;
  logic [63:0]         cursor_q, cursor_d;
  logic [12:0]         sample_pos_q, sample_pos_d;
  logic [TIME_CW-1:0]  time_pos_q, time_pos_d;
  logic [31:0]         left_time_q, left_time_d;
  logic [63:0]         accum_q, accum_d;
  logic [31:0]         delta_q, delta_d;
  logic [RUN_AW-1:0]   scan_q, scan_d;
  logic [31:0]         count_q, count_d;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;

  logic run_full, chunk_full, size_full, time_full;
  logic run_we, chunk_we, size_we, time_we;
  logic [63:0] run_rdata, time_rdata, chunk_rdata;
  logic [31:0] size_rdata, length;
  logic [31:0] chunk_number;

  assign run_full   = (run_entries_q == RUN_CW'(RUN_DEPTH));
  assign chunk_full = (chunk_entries_q == CHUNK_CW'(CHUNK_DEPTH));
  assign size_full  = (size_entries_q == SIZE_CW'(SIZE_DEPTH));
  assign time_full  = (time_entries_q == TIME_CW'(TIME_DEPTH));

  assign run_we   = cmd_i.load && in_i.func == FUNC_RUN && !run_full;
  assign chunk_we = cmd_i.load && in_i.func == FUNC_CHUNK && !chunk_full;
  assign size_we  = cmd_i.load && in_i.func == FUNC_SIZE && !size_full;
  assign time_we  = cmd_i.load && in_i.func == FUNC_TIME && !time_full;

  // run entry: first chunk in the upper half, samples per chunk in the lower
  mstw_ram #(.WIDTH(64), .DEPTH(RUN_DEPTH)) u_run_ram (
    .clk_i, .we_i(run_we), .waddr_i(run_entries_q[RUN_AW-1:0]),
    .wdata_i({in_i.value_a[31:0], in_i.value_b}),
    .re_i(cmd_i.run_rd), .raddr_i(scan_q), .rdata_o(run_rdata)
  );
  mstw_ram #(.WIDTH(64), .DEPTH(CHUNK_DEPTH)) u_chunk_ram (
    .clk_i, .we_i(chunk_we), .waddr_i(chunk_entries_q[CHUNK_AW-1:0]),
    .wdata_i(in_i.value_a),
    .re_i(cmd_i.chunk_start), .raddr_i(chunk_pos_q[CHUNK_AW-1:0]),
    .rdata_o(chunk_rdata)
  );
  mstw_ram #(.WIDTH(32), .DEPTH(SIZE_DEPTH)) u_size_ram (
    .clk_i, .we_i(size_we), .waddr_i(size_entries_q[SIZE_AW-1:0]),
    .wdata_i(in_i.value_a[31:0]),
    .re_i(cmd_i.size_rd), .raddr_i(sample_pos_q[SIZE_AW-1:0]), .rdata_o(size_rdata)
  );
  mstw_ram #(.WIDTH(64), .DEPTH(TIME_DEPTH)) u_time_ram (
    .clk_i, .we_i(time_we), .waddr_i(time_entries_q[TIME_AW-1:0]),
    .wdata_i({in_i.value_a[31:0], in_i.value_b}),
    .re_i(cmd_i.time_rd), .raddr_i(time_pos_q[TIME_AW-1:0]), .rdata_o(time_rdata)
  );

  assign chunk_number = 32'(chunk_pos_q) + 32'd1;

  always_comb begin
    stat_o.missing    = run_entries_q == '0 || chunk_entries_q == '0 ||
                        time_entries_q == '0 || sample_total_i == '0;
    stat_o.nomore     = sample_pos_q >= sample_total_i;
    stat_o.left_zero  = left_chunk_q == '0;
    stat_o.chunks_out = chunk_pos_q >= chunk_entries_q;
    stat_o.run_stop   = run_rdata[63:32] > chunk_number;
    stat_o.run_last   = (RUN_CW'(scan_q) + RUN_CW'(1)) == run_entries_q;
    stat_o.time_need  = left_time_q == '0 && time_pos_q < time_entries_q;
  end

  always_comb begin
    if (constant_size_i != '0) begin
      length = constant_size_i;
    end else if (sample_pos_q < 13'(size_entries_q)) begin
      length = size_rdata;
    end else begin
      length = '0;
    end
  end

  always_comb begin
    run_entries_d   = run_entries_q;
    chunk_entries_d = chunk_entries_q;
    size_entries_d  = size_entries_q;
    time_entries_d  = time_entries_q;
    chunk_pos_d     = chunk_pos_q;
    left_chunk_d    = left_chunk_q;
    cursor_d        = cursor_q;
    sample_pos_d    = sample_pos_q;
    time_pos_d      = time_pos_q;
    left_time_d     = left_time_q;
    accum_d         = accum_q;
    delta_d         = delta_q;
    scan_d          = scan_q;
    count_d         = count_q;
    res_valid_d     = 1'b0;
    res_d           = res_q;

    if (cmd_i.load) begin
      res_valid_d = 1'b1;
      res_d       = '0;
      res_d.status = ST_LOADED;
      if (in_i.func == FUNC_CLEAR) begin
        run_entries_d   = '0;
        chunk_entries_d = '0;
        size_entries_d  = '0;
        time_entries_d  = '0;
        chunk_pos_d     = '0;
        left_chunk_d    = '0;
        cursor_d        = '0;
        sample_pos_d    = '0;
        time_pos_d      = '0;
        left_time_d     = '0;
        accum_d         = '0;
      end else if ((in_i.func == FUNC_RUN && run_full) ||
                   (in_i.func == FUNC_CHUNK && chunk_full) ||
                   (in_i.func == FUNC_SIZE && size_full) ||
                   (in_i.func == FUNC_TIME && time_full)) begin
        res_d.status = ST_FULL;
      end
      if (run_we)   run_entries_d   = run_entries_q + RUN_CW'(1);
      if (chunk_we) chunk_entries_d = chunk_entries_q + CHUNK_CW'(1);
      if (size_we)  size_entries_d  = size_entries_q + SIZE_CW'(1);
      if (time_we)  time_entries_d  = time_entries_q + TIME_CW'(1);
    end

    if (cmd_i.emit) begin
      res_valid_d  = 1'b1;
      res_d        = '0;
      res_d.status = cmd_i.emit_code;
    end

    if (cmd_i.chunk_start) begin
      scan_d  = '0;
      count_d = '0;
    end

    // keep the count of the last run passed; stop at the first one beyond
    if (cmd_i.run_cmp && !stat_o.run_stop) begin
      count_d = run_rdata[31:0];
      scan_d  = scan_q + RUN_AW'(1);
    end

    if (cmd_i.chunk_load) begin
      left_chunk_d = count_q;
      cursor_d     = chunk_rdata;
      chunk_pos_d  = chunk_pos_q + CHUNK_CW'(1);
    end

    if (cmd_i.size_use) begin
      res_d.sample_offset = cursor_q;
      res_d.sample_length = length;
      cursor_d            = cursor_q + 64'(length);
      left_chunk_d        = left_chunk_q - 32'd1;
    end

    if (cmd_i.time_load) begin
      left_time_d = time_rdata[63:32];
      delta_d     = time_rdata[31:0];
      time_pos_d  = time_pos_q + TIME_CW'(1);
    end

    if (cmd_i.give) begin
      res_valid_d  = 1'b1;
      res_d.status = ST_GIVEN;
      if (left_time_q != '0 && time_pos_q != '0) begin
        res_d.sample_time     = accum_q;
        res_d.sample_duration = delta_q;
        accum_d               = accum_q + 64'(delta_q);
        left_time_d           = left_time_q - 32'd1;
      end else begin
        res_d.sample_time     = '0;
        res_d.sample_duration = '0;
      end
      res_d.sample_index = sample_pos_q[11:0];
      sample_pos_d       = sample_pos_q + 13'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_entries_q   <= '0;
      chunk_entries_q <= '0;
      size_entries_q  <= '0;
      time_entries_q  <= '0;
      chunk_pos_q     <= '0;
      left_chunk_q    <= '0;
      cursor_q        <= '0;
      sample_pos_q    <= '0;
      time_pos_q      <= '0;
      left_time_q     <= '0;
      accum_q         <= '0;
      scan_q          <= '0;
      count_q         <= '0;
      res_valid_q     <= 1'b0;
    end else begin
      run_entries_q   <= run_entries_d;
      chunk_entries_q <= chunk_entries_d;
      size_entries_q  <= size_entries_d;
      time_entries_q  <= time_entries_d;
      chunk_pos_q     <= chunk_pos_d;
      left_chunk_q    <= left_chunk_d;
      cursor_q        <= cursor_d;
      sample_pos_q    <= sample_pos_d;
      time_pos_q      <= time_pos_d;
      left_time_q     <= left_time_d;
      accum_q         <= accum_d;
      scan_q          <= scan_d;
      count_q         <= count_d;
      res_valid_q     <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

// ----- rtl/core/mp4_sample_table_walker.sv -----
// Top level of the sample table walker: APB registers, sequencer and datapath.
// Loads and missing/no-more errors: result in the next cycle, next item at once.
// Next sample: a run scan per chunk entered, a size read, a time run load per
// time run entered, and the result; the run scan dominates.
// Asynchronous active-low reset empties all tables and clears the walk.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module mp4_sample_table_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mstw_pkg::in_t       in_i,
  output logic                res_valid_o,
  output mstw_pkg::res_t      res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mstw_pkg::*;

  logic [31:0] constant_size_q;
  logic [12:0] sample_total_q;
  logic        cfg_we;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      constant_size_q <= '0;
      sample_total_q  <= '0;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        sample_total_q <= pwdata[12:0];
      end else begin
        constant_size_q <= pwdata;
      end
    end
  end

  assign prdata = paddr[2] ? {19'd0, sample_total_q} : constant_size_q;

  mstw_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i(in_i.func),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy)
  );

  mstw_dpath u_dpath (
    .clk_i, .rst_ni, .in_i, .constant_size_i(constant_size_q),
    .sample_total_i(sample_total_q), .cmd_i(cmd), .stat_o(stat),
    .res_valid_o, .res_o
  );
endmodule

// ----- rtl/core/mstw_checker.sv -----
// Port-level checks of the sample table walker, bound to the top level.
// Depends on mstw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mstw_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input mstw_pkg::in_t  in_i,
  input logic           res_valid_o,
  input mstw_pkg::res_t res_o,
  input logic           psel,
  input logic           penable,
  input logic           pwrite,
  input logic [2:0]     paddr,
  input logic [31:0]    pwdata,
  input logic [31:0]    prdata,
  input logic           pready
);
  import mstw_pkg::*;

  logic acc;
  assign acc = start && !busy;

  `MSTW_ASSERT(a_load_answers, acc && in_i.func < FUNC_NEXT |=> res_valid_o && !busy)
  `MSTW_ASSERT(a_next_progresses, acc && in_i.func == FUNC_NEXT |=> busy || res_valid_o)
  `MSTW_ASSERT(a_unused_silent, acc && in_i.func > FUNC_NEXT |=> !res_valid_o && !busy)
  `MSTW_NEVER(a_error_zeroed, res_valid_o && res_o.status != ST_GIVEN &&
              (res_o.sample_offset != '0 || res_o.sample_length != '0 ||
               res_o.sample_time != '0 || res_o.sample_index != '0))
endmodule

bind mp4_sample_table_walker mstw_props u_mstw_props (.*);

// ----- dv/mstw_checker.sv -----
// Checker for the sample table walker: predicts each result from the items and
// register writes it watches, and compares results field by field.
// Depends on mstw_pkg.
`timescale 1ns / 1ps
module mstw_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  mstw_pkg::in_t  in_i,
  input  logic           res_valid_o,
  input  mstw_pkg::res_t res_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           pready,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output int             fail_count,
  output int             pending
);
  import mstw_pkg::*;

  localparam logic [2:0] ADDR_CONST_SIZE = 3'd0;
  localparam logic [2:0] ADDR_TOTAL      = 3'd4;

  logic [31:0] cfg_const_size;
  logic [12:0] cfg_total;

  logic [31:0] run_first [RUN_DEPTH];
  logic [31:0] run_spc   [RUN_DEPTH];
  logic [63:0] chunk_ofs [CHUNK_DEPTH];
  logic [31:0] size_tab  [SIZE_DEPTH];
  logic [31:0] trun_cnt  [TIME_DEPTH];
  logic [31:0] trun_dlt  [TIME_DEPTH];

  int unsigned n_run, n_chunk, n_size, n_trun;
  int unsigned chunk_pos, spos, tpos;
  logic [31:0] chunk_left, trun_left;
  logic [63:0] cursor, ts_accum;

  res_t sample_q[$];

  assign pending = sample_q.size();

  function automatic logic [31:0] spc_of_chunk(int unsigned number);
    logic [31:0] cnt;
    cnt = '0;
    for (int k = 0; k < n_run; k++) begin
      if (run_first[k] > number) break;
      cnt = run_spc[k];
    end
    return cnt;
  endfunction

  task automatic clear_tables();
    n_run = 0; n_chunk = 0; n_size = 0; n_trun = 0;
    chunk_pos = 0; spos = 0; tpos = 0;
    chunk_left = '0; trun_left = '0;
    cursor = '0; ts_accum = '0;
  endtask

  task automatic resolve_sample(output res_t r);
    logic [31:0] len;
    r = '0;
    if (n_run == 0 || n_chunk == 0 || n_trun == 0 || cfg_total == 0) begin
      r.status = ST_MISSING;
      return;
    end
    if (spos >= cfg_total) begin
      r.status = ST_NOMORE;
      return;
    end
    while (chunk_left == 0) begin
      if (chunk_pos >= n_chunk) begin
        r.status = ST_CHUNKS_OUT;
        return;
      end
      chunk_left = spc_of_chunk(chunk_pos + 1);
      cursor = chunk_ofs[chunk_pos];
      chunk_pos++;
    end
    if (cfg_const_size != 0) len = cfg_const_size;
    else if (spos < n_size) len = size_tab[spos];
    else len = '0;
    r.status = ST_GIVEN;
    r.sample_offset = cursor;
    r.sample_length = len;
    cursor += len;
    chunk_left--;
    while (trun_left == 0 && tpos < n_trun) begin
      trun_left = trun_cnt[tpos];
      tpos++;
    end
    // past the time table: time and duration stay zero
    if (trun_left != 0 && tpos >= 1) begin
      r.sample_time = ts_accum;
      r.sample_duration = trun_dlt[tpos-1];
      ts_accum += trun_dlt[tpos-1];
      trun_left--;
    end
    r.sample_index = spos[11:0];
    spos++;
  endtask

  task automatic predict_item(in_t it);
    res_t r;
    r = '0;
    r.status = ST_LOADED;
    case (it.func)
      FUNC_CLEAR: clear_tables();
      FUNC_RUN:
        if (n_run >= RUN_DEPTH) r.status = ST_FULL;
        else begin
          run_first[n_run] = it.value_a[31:0];
          run_spc[n_run] = it.value_b;
          n_run++;
        end
      FUNC_CHUNK:
        if (n_chunk >= CHUNK_DEPTH) r.status = ST_FULL;
        else begin
          chunk_ofs[n_chunk] = it.value_a;
          n_chunk++;
        end
      FUNC_SIZE:
        if (n_size >= SIZE_DEPTH) r.status = ST_FULL;
        else begin
          size_tab[n_size] = it.value_a[31:0];
          n_size++;
        end
      FUNC_TIME:
        if (n_trun >= TIME_DEPTH) r.status = ST_FULL;
        else begin
          trun_cnt[n_trun] = it.value_a[31:0];
          trun_dlt[n_trun] = it.value_b;
          n_trun++;
        end
      FUNC_NEXT: resolve_sample(r);
      default: return; // unused selectors give no result
    endcase
    sample_q = {sample_q, r};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    cfg_const_size = '0;
    cfg_total = '0;
    clear_tables();
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (sample_q.size() == 0) begin
          report_mismatch("unexpected result status", 64'(res_o.status), 64'd0);
        end else begin
          want = sample_q.pop_front();
          if (res_o.status !== want.status)
            report_mismatch("status", 64'(res_o.status), 64'(want.status));
          if (res_o.sample_offset !== want.sample_offset)
            report_mismatch("sample_offset", res_o.sample_offset, want.sample_offset);
          if (res_o.sample_length !== want.sample_length)
            report_mismatch("sample_length", 64'(res_o.sample_length),
                            64'(want.sample_length));
          if (res_o.sample_time !== want.sample_time)
            report_mismatch("sample_time", res_o.sample_time, want.sample_time);
          if (res_o.sample_duration !== want.sample_duration)
            report_mismatch("sample_duration", 64'(res_o.sample_duration),
                            64'(want.sample_duration));
          if (res_o.sample_index !== want.sample_index)
            report_mismatch("sample_index", 64'(res_o.sample_index),
                            64'(want.sample_index));
        end
      end
      if (start && !busy) predict_item(in_i);
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_CONST_SIZE) cfg_const_size = pwdata;
        else if (paddr == ADDR_TOTAL) cfg_total = pwdata[12:0];
      end
    end
  end

endmodule

// ----- dv/tb_mp4_sample_table_walker.sv -----
// Testbench top for the sample table walker: drives directed and random items
// and register writes, and gives the verdict from the checker's failure count.
// Depends on mstw_pkg, mp4_sample_table_walker and mstw_checker.
`timescale 1ns / 1ps
module tb_mp4_sample_table_walker;
  import mstw_pkg::*;

  localparam logic [2:0] ADDR_CONST_SIZE = 3'd0;
  localparam logic [2:0] ADDR_TOTAL      = 3'd4;
  localparam int         ITEM_TARGET     = 1050;
  localparam int         QUIET_TAIL      = 100;
  localparam int         FILL_CHUNKS     = 40;
  localparam int         FILL_SIZES      = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          sent_items;
  bit          quiet;

  always #5 clk_i = ~clk_i;

  mp4_sample_table_walker u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mstw_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // hold start through back-to-back items; drop it only for an idle burst
  task automatic send_item(logic [2:0] f, logic [63:0] a, logic [31:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= '{func: f, value_a: a, value_b: b};
    do @(posedge clk_i); while (busy);
    sent_items++;
    if (sent_items >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
  endtask

  // drain every outstanding item, then let the sequencer settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic random_phase();
    int          n_runs, n_chunks, n_sizes, n_truns, n_next;
    logic [31:0] first;
    logic [31:0] csize;
    logic [12:0] total;
    drain();
    case ($urandom_range(0, 3))
      0, 1: csize = 32'd0;
      2: csize = $urandom;
      default: csize = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 9))
      0: total = 13'd0;
      1: total = 13'd4096;
      default: total = 13'($urandom_range(1, 40));
    endcase
    write_reg(ADDR_CONST_SIZE, csize);
    write_reg(ADDR_TOTAL, {19'd0, total});
    send_item(FUNC_CLEAR, rand64(), $urandom);
    n_runs = $urandom_range(0, 4);
    n_chunks = $urandom_range(0, 8);
    n_sizes = $urandom_range(0, 30);
    n_truns = $urandom_range(0, 4);
    first = 32'($urandom_range(0, 2));
    for (int k = 0; k < n_runs; k++) begin
      send_item(FUNC_RUN, {$urandom, first},
                ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 4)));
      first += $urandom_range(0, 3);
    end
    for (int k = 0; k < n_chunks; k++) send_item(FUNC_CHUNK, rand64(), $urandom);
    for (int k = 0; k < n_sizes; k++)
      send_item(FUNC_SIZE,
                {$urandom, ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 9999)))},
                $urandom);
    for (int k = 0; k < n_truns; k++)
      send_item(FUNC_TIME, {$urandom, 32'($urandom_range(0, 5))},
                ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
    n_next = ((total > 45) ? 45 : int'(total)) + 3;
    for (int k = 0; k < n_next; k++) begin
      // mostly walk; now and then a stray load, unused selector or clear
      case ($urandom_range(0, 19))
        0: send_item(3'($urandom_range(FUNC_RUN, FUNC_TIME)), rand64(), $urandom);
        1: send_item(3'($urandom_range(6, 7)), rand64(), $urandom);
        2: if ($urandom_range(0, 3) == 0) send_item(FUNC_CLEAR, rand64(), $urandom);
           else send_item(FUNC_NEXT, rand64(), $urandom);
        default: send_item(FUNC_NEXT, rand64(), $urandom);
      endcase
    end
  endtask

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    quiet = 1'b0;
    sent_items = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: missing tables, zero-sample chunk, wrap, size and time ends
    write_reg(ADDR_CONST_SIZE, 32'd0);
    write_reg(ADDR_TOTAL, 32'd5);
    send_item(FUNC_NEXT, '0, '0);
    send_item(FUNC_CLEAR, '1, '1);
    send_item(FUNC_RUN, 64'd0, 32'd2);
    send_item(FUNC_RUN, 64'd3, 32'd0);
    send_item(FUNC_RUN, {32'hFFFF_FFFF, 32'd4}, 32'd1);
    send_item(FUNC_CHUNK, 64'hFFFF_FFFF_FFFF_FFF0, '0);
    send_item(FUNC_CHUNK, 64'd0, 32'hFFFF_FFFF);
    send_item(FUNC_CHUNK, 64'h8000_0000_0000_1000, '0);
    send_item(FUNC_SIZE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_item(FUNC_SIZE, 64'd0, '0);
    send_item(FUNC_TIME, 64'd0, 32'd9);
    send_item(FUNC_TIME, 64'd2, 32'hFFFF_FFFF);
    send_item(FUNC_TIME, 64'd1, 32'd3);
    repeat (6) send_item(FUNC_NEXT, '1, '0);
    send_item(3'd6, '1, '1);
    send_item(3'd7, '0, '0);
    send_item(FUNC_NEXT, '0, '0);

    // fill the run and time tables past their depth, then walk a long track
    drain();
    write_reg(ADDR_CONST_SIZE, 32'hFFFF_FFFF);
    write_reg(ADDR_TOTAL, 32'd4096);
    send_item(FUNC_CLEAR, '0, '0);
    for (int k = 0; k <= RUN_DEPTH; k++) send_item(FUNC_RUN, 64'(k + 1), 32'd4);
    for (int k = 0; k < FILL_CHUNKS; k++) send_item(FUNC_CHUNK, rand64(), '0);
    for (int k = 0; k < FILL_SIZES; k++) send_item(FUNC_SIZE, rand64(), '0);
    for (int k = 0; k <= TIME_DEPTH; k++) send_item(FUNC_TIME, 64'd3, $urandom);
    repeat (150) send_item(FUNC_NEXT, '0, '0);
    drain();
    write_reg(ADDR_CONST_SIZE, 32'd0);
    repeat (20) send_item(FUNC_NEXT, '0, '0);

    while (sent_items < ITEM_TARGET) random_phase();

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
